// File: src/dns_rp_pkg.sv
// Shared widths and codes of the DNS response parser.
package dns_rp_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned TdataW  = 248;
  localparam int unsigned PtrW    = 14;

  localparam logic [1:0] StatusParse = 2'd0;
  localparam logic [1:0] StatusDone  = 2'd1;
  localparam logic [1:0] StatusError = 2'd2;

  localparam logic [1:0] KindIpv4  = 2'd0;
  localparam logic [1:0] KindIpv6  = 2'd1;
  localparam logic [1:0] KindCname = 2'd2;

  localparam logic [15:0] TypeA     = 16'd1;
  localparam logic [15:0] TypeCname = 16'd5;
  localparam logic [15:0] TypeAaaa  = 16'd28;

endpackage

// File: src/dns_response_parser_top.sv
// DNS response parser: byte stream in, one result item per byte out.
// Each accepted byte's result item is registered and appears on the master side in the following cycle.
// Throughput: one byte per cycle while the master side does not stall; each byte is a single parse-state update
// between the parse registers and the result register.
// Reset: parse state returns to the header id phase with all fields zero and
// the result register empties; a byte with message start set restarts the parse.
module dns_response_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  input  logic         s_axis_tuser,   // message_start[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], record_valid[2], record_ttl[34:3], record_class[50:35],
  // address_high[114:51], address_low[178:115], record_number[194:179],
  // name_offset[208:195], message_id[224:209], message_flags[240:225], zero pad
  output logic [247:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // record_kind[1:0]
);

  localparam logic [4:0] PhId     = 5'd0;
  localparam logic [4:0] PhFlags  = 5'd1;
  localparam logic [4:0] PhQdcnt  = 5'd2;
  localparam logic [4:0] PhAncnt  = 5'd3;
  localparam logic [4:0] PhNscnt  = 5'd4;
  localparam logic [4:0] PhArcnt  = 5'd5;
  localparam logic [4:0] PhQlen   = 5'd6;
  localparam logic [4:0] PhQlabel = 5'd7;
  localparam logic [4:0] PhQtype  = 5'd8;
  localparam logic [4:0] PhQclass = 5'd9;
  localparam logic [4:0] PhAlen   = 5'd10;
  localparam logic [4:0] PhAlabel = 5'd11;
  localparam logic [4:0] PhAptr   = 5'd12;
  localparam logic [4:0] PhAtype  = 5'd13;
  localparam logic [4:0] PhAclass = 5'd14;
  localparam logic [4:0] PhAttl   = 5'd15;
  localparam logic [4:0] PhRdlen  = 5'd16;
  localparam logic [4:0] PhV4     = 5'd17;
  localparam logic [4:0] PhV6     = 5'd18;
  localparam logic [4:0] PhClen   = 5'd19;
  localparam logic [4:0] PhClabel = 5'd20;
  localparam logic [4:0] PhCptr   = 5'd21;
  localparam logic [4:0] PhDone   = 5'd22;
  localparam logic [4:0] PhError  = 5'd23;

  logic [4:0]   phase_q, phase_d, phase_c;
  logic [7:0]   bpos_q, bpos_d, bpos_c;
  logic [7:0]   flen_q, flen_d, flen_c;
  logic [15:0]  total_q, total_d, total_c;
  logic [15:0]  apos_q, apos_d, apos_c;
  logic [15:0]  id_q, id_d, id_c;
  logic [15:0]  flags_q, flags_d, flags_c;
  logic [15:0]  atype_q, atype_d, atype_c;
  logic [15:0]  aclass_q, aclass_d, aclass_c;
  logic [31:0]  ttl_q, ttl_d, ttl_c;
  logic [dns_rp_pkg::PtrW-1:0] ptr_q, ptr_d, ptr_c;
  logic [127:0] acc_q, acc_d, acc_c;

  logic [7:0]   c;
  logic         start;
  logic         fin;
  logic [1:0]   fin_kind;
  logic [15:0]  apos_inc;

  logic [1:0]   status;
  logic         rec_valid;
  logic [1:0]   rec_kind;
  logic [31:0]  rec_ttl;
  logic [15:0]  rec_class;
  logic [63:0]  addr_high;
  logic [63:0]  addr_low;
  logic [15:0]  rec_number;
  logic [dns_rp_pkg::PtrW-1:0] rec_offset;

  logic                            out_valid_q;
  logic [dns_rp_pkg::TdataW-1:0]   out_data_q;
  logic [1:0]                      out_user_q;
  logic                            in_acc;

  assign c     = s_axis_tdata;
  assign start = s_axis_tuser;

  assign phase_c  = start ? PhId : phase_q;
  assign bpos_c   = start ? 8'd0 : bpos_q;
  assign flen_c   = start ? 8'd2 : flen_q;
  assign total_c  = start ? 16'd0 : total_q;
  assign apos_c   = start ? 16'd0 : apos_q;
  assign id_c     = start ? 16'd0 : id_q;
  assign flags_c  = start ? 16'd0 : flags_q;
  assign atype_c  = start ? 16'd0 : atype_q;
  assign aclass_c = start ? 16'd0 : aclass_q;
  assign ttl_c    = start ? 32'd0 : ttl_q;
  assign ptr_c    = start ? '0 : ptr_q;
  assign acc_c    = start ? 128'd0 : acc_q;

  always_comb begin
    phase_d  = phase_c;
    bpos_d   = bpos_c;
    flen_d   = flen_c;
    total_d  = total_c;
    apos_d   = apos_c;
    id_d     = id_c;
    flags_d  = flags_c;
    atype_d  = atype_c;
    aclass_d = aclass_c;
    ttl_d    = ttl_c;
    ptr_d    = ptr_c;
    acc_d    = acc_c;
    fin      = 1'b0;
    fin_kind = dns_rp_pkg::KindIpv4;

    unique case (phase_c) inside
      PhId: begin
        if (bpos_c == 8'd0) begin
          id_d = {c, 8'h00}; bpos_d = 8'd1;
        end else begin
          id_d = {id_c[15:8], c}; phase_d = PhFlags; bpos_d = 8'd0; flen_d = 8'd2;
        end
      end
      PhFlags: begin
        if (bpos_c == 8'd0) begin
          flags_d = {c, 8'h00}; bpos_d = 8'd1;
        end else begin
          flags_d = {flags_c[15:8], c}; phase_d = PhQdcnt; bpos_d = 8'd0; flen_d = 8'd2;
        end
      end
      PhAncnt: begin
        if (bpos_c == 8'd0) begin
          total_d = {c, 8'h00}; bpos_d = 8'd1;
        end else begin
          total_d = {total_c[15:8], c}; phase_d = PhNscnt; bpos_d = 8'd0; flen_d = 8'd2;
        end
      end
      PhQdcnt, PhNscnt, PhArcnt, PhQtype: begin
        if (bpos_c == 8'd0) begin
          bpos_d = 8'd1;
        end else begin
          bpos_d = 8'd0;
          flen_d = 8'd2;
          if (phase_c == PhQdcnt) phase_d = PhAncnt;
          else if (phase_c == PhNscnt) phase_d = PhArcnt;
          else if (phase_c == PhArcnt) begin
            phase_d = PhQlen; flen_d = 8'd1;
          end else phase_d = PhQclass;
        end
      end
      PhQclass: begin
        if (bpos_c == 8'd0) begin
          bpos_d = 8'd1;
        end else begin
          apos_d = 16'd0;
          bpos_d = 8'd0;
          if (total_c == 16'd0) begin
            phase_d = PhDone; flen_d = 8'd0;
          end else begin
            phase_d = PhAlen; flen_d = 8'd1; ptr_d = '0;
          end
        end
      end
      PhQlen: begin
        bpos_d = 8'd0;
        if (c == 8'd0) begin
          phase_d = PhQtype; flen_d = 8'd2;
        end else begin
          phase_d = PhQlabel; flen_d = c;
        end
      end
      PhQlabel, PhAlabel, PhClabel: begin
        if (bpos_c >= flen_c) begin
          phase_d = PhError; bpos_d = 8'd0; flen_d = 8'd0;
        end else begin
          bpos_d = bpos_c + 8'd1;
          if (bpos_d == flen_c) begin
            bpos_d = 8'd0;
            flen_d = 8'd1;
            if (phase_c == PhQlabel) phase_d = PhQlen;
            else if (phase_c == PhAlabel) phase_d = PhAlen;
            else phase_d = PhClen;
          end
        end
      end
      PhAlen: begin
        bpos_d = 8'd0;
        if (c == 8'd0) begin
          phase_d = PhAtype; flen_d = 8'd2;
        end else if (c[7:6] == 2'b11) begin
          ptr_d = {c[5:0], 8'h00}; phase_d = PhAptr; flen_d = 8'd2; bpos_d = 8'd1;
        end else begin
          phase_d = PhAlabel; flen_d = c;
        end
      end
      PhAptr: begin
        ptr_d = {ptr_c[13:8], c}; phase_d = PhAtype; bpos_d = 8'd0; flen_d = 8'd2;
      end
      PhAtype: begin
        if (bpos_c == 8'd0) begin
          atype_d = {c, 8'h00}; bpos_d = 8'd1;
        end else begin
          atype_d = {atype_c[15:8], c}; phase_d = PhAclass; bpos_d = 8'd0; flen_d = 8'd2;
        end
      end
      PhAclass: begin
        if (bpos_c == 8'd0) begin
          aclass_d = {c, 8'h00}; bpos_d = 8'd1;
        end else begin
          aclass_d = {aclass_c[15:8], c}; phase_d = PhAttl; bpos_d = 8'd0; flen_d = 8'd4;
        end
      end
      PhAttl: begin
        if (bpos_c == 8'd0) ttl_d = {24'd0, c};
        else ttl_d = {ttl_c[23:0], c};
        bpos_d = bpos_c + 8'd1;
        if (bpos_d >= 8'd4) begin
          phase_d = PhRdlen; bpos_d = 8'd0; flen_d = 8'd2;
        end
      end
      PhRdlen: begin
        if (bpos_c == 8'd0) begin
          bpos_d = 8'd1;
        end else begin
          acc_d  = 128'd0;
          bpos_d = 8'd0;
          if (atype_c == dns_rp_pkg::TypeA) begin
            phase_d = PhV4; flen_d = 8'd4;
          end else if (atype_c == dns_rp_pkg::TypeAaaa) begin
            phase_d = PhV6; flen_d = 8'd16;
          end else if (atype_c == dns_rp_pkg::TypeCname) begin
            phase_d = PhClen; flen_d = 8'd1;
          end else begin
            phase_d = PhError; flen_d = 8'd0;
          end
        end
      end
      PhV4, PhV6: begin
        acc_d  = {acc_c[119:0], c};
        bpos_d = bpos_c + 8'd1;
        if (bpos_d >= flen_c) begin
          fin      = 1'b1;
          fin_kind = (phase_c == PhV4) ? dns_rp_pkg::KindIpv4 : dns_rp_pkg::KindIpv6;
        end
      end
      PhClen: begin
        bpos_d = 8'd0;
        if (c == 8'd0) begin
          fin = 1'b1; fin_kind = dns_rp_pkg::KindCname;
        end else if (c[7:6] == 2'b11) begin
          phase_d = PhCptr; flen_d = 8'd2; bpos_d = 8'd1;
        end else begin
          phase_d = PhClabel; flen_d = c;
        end
      end
      PhCptr: begin
        fin = 1'b1; fin_kind = dns_rp_pkg::KindCname;
      end
      PhDone, PhError: begin
      end
      default: begin
        phase_d = PhError; bpos_d = 8'd0; flen_d = 8'd0;
      end
    endcase

    apos_inc   = apos_c + 16'd1;
    rec_valid  = fin;
    rec_kind   = 2'd0;
    rec_ttl    = 32'd0;
    rec_class  = 16'd0;
    addr_high  = 64'd0;
    addr_low   = 64'd0;
    rec_number = 16'd0;
    rec_offset = '0;
    if (fin) begin
      rec_kind   = fin_kind;
      rec_ttl    = ttl_c;
      rec_class  = aclass_c;
      rec_number = apos_c;
      rec_offset = ptr_c;
      if (fin_kind != dns_rp_pkg::KindCname) begin
        addr_high = acc_d[127:64];
        addr_low  = acc_d[63:0];
      end
      apos_d = apos_inc;
      bpos_d = 8'd0;
      if (apos_inc == total_c) begin
        phase_d = PhDone; flen_d = 8'd0;
      end else begin
        phase_d = PhAlen; flen_d = 8'd1; ptr_d = '0;
      end
    end

    if (phase_d == PhDone) status = dns_rp_pkg::StatusDone;
    else if (phase_d == PhError) status = dns_rp_pkg::StatusError;
    else status = dns_rp_pkg::StatusParse;
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhId;
      bpos_q      <= 8'd0;
      flen_q      <= 8'd2;
      total_q     <= 16'd0;
      apos_q      <= 16'd0;
      id_q        <= 16'd0;
      flags_q     <= 16'd0;
      atype_q     <= 16'd0;
      aclass_q    <= 16'd0;
      ttl_q       <= 32'd0;
      ptr_q       <= '0;
      acc_q       <= 128'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        bpos_q      <= bpos_d;
        flen_q      <= flen_d;
        total_q     <= total_d;
        apos_q      <= apos_d;
        id_q        <= id_d;
        flags_q     <= flags_d;
        atype_q     <= atype_d;
        aclass_q    <= aclass_d;
        ttl_q       <= ttl_d;
        ptr_q       <= ptr_d;
        acc_q       <= acc_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {7'd0, flags_d, id_d, rec_offset, rec_number, addr_low, addr_high,
                     rec_class, rec_ttl, rec_valid, status};
      out_user_q <= rec_kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: sim/dns_response_parser_top_tb.sv
// Self-checking testbench for the DNS response parser: random DNS messages, per-byte checks.
module dns_response_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned   ItemsPerPhase = 220;
  localparam int unsigned   LongHold      = 150;
  localparam int unsigned   StallLimit    = 4000;
  localparam int unsigned   DrainCycles   = 8;
  localparam logic [1:0]    PtrTag        = 2'b11;
  localparam logic [7:0]    NameEnd       = 8'h00;

  typedef enum logic [4:0] {
    PhId, PhFlags, PhQdCount, PhAnCount, PhNsCount, PhArCount,
    PhQLen, PhQLabel, PhQType, PhQClass,
    PhALen, PhALabel, PhAPtr, PhAType, PhAClass, PhATtl, PhRdLen,
    PhV4, PhV6, PhCLen, PhCLabel, PhCPtr, PhDone, PhError
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] flags;
    logic [15:0] id;
    logic [13:0] name_off;
    logic [15:0] number;
    logic [63:0] addr_lo;
    logic [63:0] addr_hi;
    logic [15:0] rclass;
    logic [31:0] ttl;
    logic        valid;
    logic [1:0]  status;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [247:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  stream_byte_t  bytes_to_send[$];
  parse_result_t parse_results_due[$];
  logic [7:0]    msg_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        pressure_on = 1'b0;
  int unsigned hold_cnt;
  int unsigned quiet_cycles;
  int unsigned mismatch_cnt = 0;

  parse_phase_e ph;
  logic [7:0]   pos;
  logic [7:0]   flen;
  logic [15:0]  an_total;
  logic [15:0]  an_index;
  logic [15:0]  hdr_id;
  logic [15:0]  hdr_flags;
  logic [15:0]  ans_type;
  logic [15:0]  ans_class;
  logic [31:0]  ans_ttl;
  logic [13:0]  ptr_off;
  logic [63:0]  addr_hi;
  logic [63:0]  addr_lo;

  dns_response_parser_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void enter(parse_phase_e next, logic [7:0] len);
    ph = next;
    pos = 8'd0;
    flen = len;
  endfunction

  function automatic void clear_parser();
    enter(PhId, 8'd2);
    an_total = '0;
    an_index = '0;
    hdr_id = '0;
    hdr_flags = '0;
    ans_type = '0;
    ans_class = '0;
    ans_ttl = '0;
    ptr_off = '0;
    addr_hi = '0;
    addr_lo = '0;
  endfunction

  function automatic void start_answer();
    ptr_off = '0;
    enter(PhALen, 8'd1);
  endfunction

  function automatic logic [15:0] pair_in(logic [15:0] cur, logic [7:0] c, logic second);
    return second ? {cur[15:8], c} : {c, 8'h00};
  endfunction

  function automatic void pair_step(logic second, parse_phase_e next, logic [7:0] len);
    if (second) enter(next, len);
    else pos = 8'd1;
  endfunction

  function automatic parse_result_t close_record(logic [1:0] kind);
    parse_result_t r;
    r = '0;
    r.valid = 1'b1;
    r.kind = kind;
    r.ttl = ans_ttl;
    r.rclass = ans_class;
    r.addr_hi = (kind == dns_rp_pkg::KindCname) ? 64'd0 : addr_hi;
    r.addr_lo = (kind == dns_rp_pkg::KindCname) ? 64'd0 : addr_lo;
    r.number = an_index;
    r.name_off = ptr_off;
    an_index = an_index + 16'd1;
    if (an_index == an_total) enter(PhDone, 8'd0);
    else start_answer();
    return r;
  endfunction

  function automatic parse_result_t parse_dns_byte(logic [7:0] c, logic restart);
    parse_result_t r;
    logic second;
    r = '0;
    if (restart) clear_parser();
    second = (pos != 8'd0);
    case (ph) inside
      PhId: begin
        hdr_id = pair_in(hdr_id, c, second);
        pair_step(second, PhFlags, 8'd2);
      end
      PhFlags: begin
        hdr_flags = pair_in(hdr_flags, c, second);
        pair_step(second, PhQdCount, 8'd2);
      end
      PhQdCount: pair_step(second, PhAnCount, 8'd2);
      PhAnCount: begin
        an_total = pair_in(an_total, c, second);
        pair_step(second, PhNsCount, 8'd2);
      end
      PhNsCount: pair_step(second, PhArCount, 8'd2);
      PhArCount: pair_step(second, PhQLen, 8'd1);
      PhQLen: begin
        if (c == NameEnd) enter(PhQType, 8'd2);
        else enter(PhQLabel, c);
      end
      PhQLabel, PhALabel, PhCLabel: begin
        if (pos >= flen) begin
          enter(PhError, 8'd0);
        end else begin
          pos = pos + 8'd1;
          if (pos == flen) begin
            if (ph == PhQLabel) enter(PhQLen, 8'd1);
            else if (ph == PhALabel) enter(PhALen, 8'd1);
            else enter(PhCLen, 8'd1);
          end
        end
      end
      PhQType: pair_step(second, PhQClass, 8'd2);
      PhQClass: begin
        if (second) begin
          an_index = '0;
          if (an_total == 16'd0) enter(PhDone, 8'd0);
          else start_answer();
        end else begin
          pos = 8'd1;
        end
      end
      PhALen: begin
        if (c == NameEnd) begin
          enter(PhAType, 8'd2);
        end else if (c[7:6] == PtrTag) begin
          ptr_off = {c[5:0], 8'h00};
          enter(PhAPtr, 8'd2);
          pos = 8'd1;
        end else begin
          enter(PhALabel, c);
        end
      end
      PhAPtr: begin
        ptr_off = {ptr_off[13:8], c};
        enter(PhAType, 8'd2);
      end
      PhAType: begin
        ans_type = pair_in(ans_type, c, second);
        pair_step(second, PhAClass, 8'd2);
      end
      PhAClass: begin
        ans_class = pair_in(ans_class, c, second);
        pair_step(second, PhATtl, 8'd4);
      end
      PhATtl: begin
        ans_ttl = second ? {ans_ttl[23:0], c} : {24'd0, c};
        pos = pos + 8'd1;
        if (pos >= 8'd4) enter(PhRdLen, 8'd2);
      end
      PhRdLen: begin
        if (second) begin
          addr_hi = '0;
          addr_lo = '0;
          if (ans_type == dns_rp_pkg::TypeA) enter(PhV4, 8'd4);
          else if (ans_type == dns_rp_pkg::TypeAaaa) enter(PhV6, 8'd16);
          else if (ans_type == dns_rp_pkg::TypeCname) enter(PhCLen, 8'd1);
          else enter(PhError, 8'd0);
        end else begin
          pos = 8'd1;
        end
      end
      PhV4, PhV6: begin
        {addr_hi, addr_lo} = {addr_hi[55:0], addr_lo, c};
        pos = pos + 8'd1;
        if (pos >= flen) begin
          r = close_record((ph == PhV4) ? dns_rp_pkg::KindIpv4 : dns_rp_pkg::KindIpv6);
        end
      end
      PhCLen: begin
        if (c == NameEnd) begin
          r = close_record(dns_rp_pkg::KindCname);
        end else if (c[7:6] == PtrTag) begin
          enter(PhCPtr, 8'd2);
          pos = 8'd1;
        end else begin
          enter(PhCLabel, c);
        end
      end
      PhCPtr: r = close_record(dns_rp_pkg::KindCname);
      PhDone, PhError: ;
      default: enter(PhError, 8'd0);
    endcase
    r.status = (ph == PhDone) ? dns_rp_pkg::StatusDone :
               (ph == PhError) ? dns_rp_pkg::StatusError : dns_rp_pkg::StatusParse;
    r.id = hdr_id;
    r.flags = hdr_flags;
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stream_byte_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
      clear_parser();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_results_due.push_back(parse_dns_byte(s_axis_tdata, s_axis_tuser));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = bytes_to_send.pop_front();
          s_axis_tdata <= nxt.data;
          s_axis_tuser <= nxt.start;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t got;
    parse_result_t want;
    bit ok;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[240:0]};
        if (parse_results_due.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatch_cnt++;
        end else begin
          want = parse_results_due.pop_front();
          ok = field_ok("status", want.status, got.status)
             & field_ok("record_valid", want.valid, got.valid)
             & field_ok("record_kind", want.kind, got.kind)
             & field_ok("record_ttl", want.ttl, got.ttl)
             & field_ok("record_class", want.rclass, got.rclass)
             & field_ok("address_high", want.addr_hi, got.addr_hi)
             & field_ok("address_low", want.addr_lo, got.addr_lo)
             & field_ok("record_number", want.number, got.number)
             & field_ok("name_offset", want.name_off, got.name_off)
             & field_ok("message_id", want.id, got.id)
             & field_ok("message_flags", want.flags, got.flags);
          if (!ok) mismatch_cnt++;
        end
      end
      if (pressure_on && hold_cnt < LongHold) begin
        m_axis_tready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put16(logic [15:0] v);
    msg_q.push_back(v[15:8]);
    msg_q.push_back(v[7:0]);
  endtask

  task automatic put_pointer();
    msg_q.push_back({PtrTag, 6'($urandom)});
    msg_q.push_back(8'($urandom));
  endtask

  task automatic put_labels(int n);
    int len;
    repeat (n) begin
      case ($urandom_range(0, 39))
        0: len = $urandom_range(64, 67);
        1: len = $urandom_range(128, 130);
        default: len = $urandom_range(1, 5);
      endcase
      msg_q.push_back(8'(len));
      repeat (len) msg_q.push_back(8'($urandom));
    end
  endtask

  task automatic flush_message(int keep);
    for (int k = 0; k < keep; k++) begin
      bytes_to_send.push_back('{data: msg_q[k], start: (k == 0)});
    end
    msg_q.delete();
  endtask

  task automatic add_message();
    int n_ans;
    int sel;
    logic [15:0] an_field;
    logic [15:0] rtype;
    bit broken;
    n_ans = $urandom_range(0, 3);
    an_field = 16'(n_ans);
    case ($urandom_range(0, 14))
      0: an_field = 16'hFFFF;
      1: an_field = 16'(n_ans + $urandom_range(1, 2));
      default: ;
    endcase
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    put16(an_field);
    put16(16'($urandom));
    put16(16'($urandom));
    if ($urandom_range(0, 29) == 0) msg_q.push_back({PtrTag, 6'($urandom)});
    put_labels($urandom_range(0, 2));
    msg_q.push_back(NameEnd);
    put16(16'($urandom));
    put16(16'($urandom));
    broken = 1'b0;
    for (int i = 0; i < n_ans && !broken; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        put_pointer();
      end else begin
        put_labels($urandom_range(0, 2));
        msg_q.push_back(NameEnd);
      end
      sel = $urandom_range(0, 19);
      if (sel < 8) rtype = dns_rp_pkg::TypeA;
      else if (sel < 14) rtype = dns_rp_pkg::TypeAaaa;
      else if (sel < 19) rtype = dns_rp_pkg::TypeCname;
      else begin
        rtype = 16'($urandom);
        if (rtype == dns_rp_pkg::TypeA || rtype == dns_rp_pkg::TypeAaaa ||
            rtype == dns_rp_pkg::TypeCname) rtype = 16'h00FF;
      end
      put16(rtype);
      put16(16'($urandom));
      put16(16'($urandom));
      put16(16'($urandom));
      put16(16'($urandom));
      if (rtype == dns_rp_pkg::TypeA) begin
        repeat (4) msg_q.push_back(8'($urandom));
      end else if (rtype == dns_rp_pkg::TypeAaaa) begin
        repeat (16) msg_q.push_back(8'($urandom));
      end else if (rtype == dns_rp_pkg::TypeCname) begin
        put_labels($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0) msg_q.push_back(NameEnd);
        else put_pointer();
      end else begin
        broken = 1'b1;
      end
    end
    repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) flush_message($urandom_range(1, msg_q.size() - 1));
    else flush_message(msg_q.size());
  endtask

  task automatic add_items(int unsigned count);
    int unsigned goal;
    goal = bytes_to_send.size() + count;
    while (bytes_to_send.size() < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          bytes_to_send.push_back('{data: 8'($urandom), start: ($urandom_range(0, 7) == 0)});
        end
      end else begin
        add_message();
      end
    end
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || s_axis_tvalid || parse_results_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    msg_q = '{8'h12, 8'h34, 8'hAB};
    flush_message(msg_q.size());
    put16(16'hFFFF);
    put16(16'h0000);
    put16(16'hFFFF);
    put16(16'h0000);
    put16(16'hFFFF);
    put16(16'h0000);
    msg_q.push_back(NameEnd);
    put16(16'hFFFF);
    put16(16'h0000);
    msg_q.push_back(8'hFF);
    msg_q.push_back(8'h00);
    flush_message(msg_q.size());
    wait_drained();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          send_idle_pct <= 82;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 82;
        end
        3: begin
          send_idle_pct <= 21;
          recv_stall_pct <= 21;
        end
        4: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
          pressure_on <= 1'b1;
        end
        default: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
        end
      endcase
      @(negedge clk_i);
      add_items(ItemsPerPhase);
      wait_drained();
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && parse_results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
